/* rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, codes and sizes of the serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int PAYLOAD_LEN = 16;
	localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
	localparam int FILL_W      = $clog2(PAYLOAD_LEN + 1);
	localparam int NUM_BANKS   = 2;
	localparam int BANK_W      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int BUSY_W      = $clog2(NUM_BANKS + 1);
	localparam int ADDR_W      = BANK_W + IDX_W;
	localparam int RAM_DEPTH   = 1 << ADDR_W;
	localparam int CMDQ_DEPTH  = 2;

	localparam logic [7:0] HDR_NONE   = 8'd0;
	localparam logic [7:0] HDR_VALUE  = 8'd110;
	localparam logic [7:0] HDR_CONFIG = 8'd111;
	localparam logic [7:0] HDR_QUERY  = 8'd114;
	localparam logic [7:0] END_MARK   = 8'h00;

	typedef enum logic [1:0] {
		K_VALUE  = 2'd0,
		K_CONFIG = 2'd1,
		K_QUERY  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BANK_W-1:0]  bank;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_t;

	function automatic logic [7:0] kind_hdr(input kind_t k);
		logic [7:0] h;
		h = HDR_QUERY;
		case (k)
			K_VALUE:  h = HDR_VALUE;
			K_CONFIG: h = HDR_CONFIG;
			default:  h = HDR_QUERY;
		endcase
		return h;
	endfunction

endpackage

/* rtl/spd_ram.sv */
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/spd_front.sv */
// ----------------------------------------------------------------------------
// spd_front
// Receive side: tracks the pending header, stores payload bytes into the
// free bank and queues a send command when a packet is terminated.
// ----------------------------------------------------------------------------
module spd_front import spd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic       q_full,
	input  logic       bank_done,
	output push_t      push,
	output wr_t        wr
);

	logic [7:0]        pending_q;
	logic [FILL_W-1:0] fill_q;
	logic [BANK_W-1:0] wbank_q;
	logic [BUSY_W-1:0] busy_q;

	logic  need_bank;
	logic  term;
	logic  acc;
	logic  push_pay;
	kind_t kind;

	always_comb begin
		need_bank = 1'b0;
		term      = 1'b0;
		kind      = K_QUERY;
		if (pending_q != HDR_NONE) begin
			case (pending_q)
				HDR_VALUE: begin
					kind = K_VALUE;
					if (fill_q == '0) need_bank = 1'b1;
					else term = 1'b1;
				end
				HDR_CONFIG: begin
					kind = K_CONFIG;
					if (fill_q < FILL_W'(PAYLOAD_LEN)) need_bank = 1'b1;
					else term = 1'b1;
				end
				HDR_QUERY: begin
					kind = K_QUERY;
					term = 1'b1;
				end
				default: ;
			endcase
		end
		// hold payload bytes while both banks wait on the sender, end bytes while the queue is full
		rx_ready = !((need_bank && busy_q == BUSY_W'(NUM_BANKS)) || (term && q_full));
		acc      = rx_valid && rx_ready;

		wr.en   = acc && need_bank;
		wr.addr = {wbank_q, fill_q[IDX_W-1:0]};
		wr.data = rx_byte;

		push.valid    = acc && term && (rx_byte == END_MARK);
		push.cmd.kind = kind;
		push.cmd.bank = wbank_q;
		push_pay      = push.valid && (kind != K_QUERY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= HDR_NONE;
			fill_q    <= '0;
			wbank_q   <= '0;
			busy_q    <= '0;
		end else begin
			if (acc) begin
				if (pending_q == HDR_NONE) begin
					pending_q <= rx_byte;
				end else if (need_bank) begin
					fill_q <= fill_q + FILL_W'(1);
				end else begin
					// completes or breaks the packet: drop back to idle
					pending_q <= HDR_NONE;
					fill_q    <= '0;
				end
			end
			if (push_pay) begin
				wbank_q <= wbank_q + BANK_W'(1);
			end
			if (push_pay && !bank_done) begin
				busy_q <= busy_q + BUSY_W'(1);
			end else if (!push_pay && bank_done) begin
				busy_q <= busy_q - BUSY_W'(1);
			end
		end
	end

endmodule

/* rtl/spd_cmdq.sv */
// ----------------------------------------------------------------------------
// spd_cmdq
// Short command queue between the receive side and the send side.
// ----------------------------------------------------------------------------
module spd_cmdq import spd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output cmd_t  head
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             ent_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;

	assign full    = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = ent_q[rd_q];
	assign do_push = push.valid && !full;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wrap_inc(wr_q);
			if (pop)     rd_q <= wrap_inc(rd_q);
			if (do_push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!do_push && pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/spd_back.sv */
// ----------------------------------------------------------------------------
// spd_back
// Send side: pops a command, emits its header, then streams the stored
// payload bytes out of the bank through the output register.
// ----------------------------------------------------------------------------
module spd_back import spd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output rd_t        rd,
	input  logic [7:0] rdata,
	output logic       bank_done,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic       tx_valid,
	input  logic       tx_ready
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_DATA = 2'b10
	} bstate_t;

	bstate_t           state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic [BANK_W-1:0] bank_q;
	logic              tx_valid_q;
	logic [7:0]        tx_byte_q;
	logic              tx_last_q;
	logic              load;
	logic              at_last;

	assign load     = !tx_valid_q || tx_ready;
	assign at_last  = (idx_q == last_idx_q);
	assign tx_valid = tx_valid_q;
	assign tx_byte  = tx_byte_q;
	assign tx_last  = tx_last_q;

	always_comb begin
		q_pop     = 1'b0;
		bank_done = 1'b0;
		rd.en     = 1'b0;
		rd.addr   = {bank_q, idx_q + IDX_W'(1)};
		unique case (state_q)
			B_IDLE: begin
				if (load && !q_empty) begin
					q_pop = 1'b1;
					// prefetch the first stored byte while the header goes out
					if (q_head.kind != K_QUERY) begin
						rd.en   = 1'b1;
						rd.addr = {q_head.bank, {IDX_W{1'b0}}};
					end
				end
			end
			B_DATA: begin
				if (load) begin
					if (at_last) bank_done = 1'b1;
					else rd.en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			tx_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (load) tx_valid_q <= q_pop;
					if (q_pop && q_head.kind != K_QUERY) state_q <= B_DATA;
				end
				B_DATA: begin
					if (load) begin
						tx_valid_q <= 1'b1;
						if (at_last) state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (q_pop) begin
					tx_byte_q  <= kind_hdr(q_head.kind);
					tx_last_q  <= (q_head.kind == K_QUERY);
					idx_q      <= '0;
					bank_q     <= q_head.bank;
					last_idx_q <= (q_head.kind == K_CONFIG) ? IDX_W'(PAYLOAD_LEN - 1) : '0;
				end
			end
			B_DATA: begin
				if (load) begin
					tx_byte_q <= rdata;
					tx_last_q <= at_last;
					idx_q     <= idx_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/serial_packet_deframer.sv */
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Reassembles value, config and query packets from received serial bytes
// and forwards each complete packet, flagging its final byte.
//
//   channel  signals                      dir  beat
//   rx       rx_valid rx_ready rx_byte    in   one received byte
//   tx       tx_valid tx_ready tx_byte    out  one forwarded byte
//            tx_last                           (tx_last on final byte)
//
// The receive side takes one byte a cycle unless stalled; payload goes into one of two
// RAM banks, so a second packet can fill while the first is sent.
// The send side gives one byte a cycle while tx_ready is high: header, then one stored
// byte per cycle read from the RAM port.
// rx stalls only when both banks or the command queue are still held by
// the send side. Reset clears framing and queue state; the RAM is not cleared.
// ----------------------------------------------------------------------------
module serial_packet_deframer import spd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       rx_valid,
	output logic       rx_ready,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic       tx_valid,
	input  logic       tx_ready
);

	push_t      push;
	wr_t        wr;
	rd_t        rd;
	cmd_t       q_head;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	logic       bank_done;
	logic [7:0] rdata;

	spd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.q_full    (q_full),
		.bank_done (bank_done),
		.push      (push),
		.wr        (wr)
	);

	spd_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	spd_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rdata)
	);

	spd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rd        (rd),
		.rdata     (rdata),
		.bank_done (bank_done),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready)
	);

endmodule
